[rtl/lpir_pkg.sv]
// Shared types and constants of the length-prefixed image receiver.
package lpir_pkg;

  // Field widths of the channels
  localparam int unsigned OpW     = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatW   = 3;
  localparam int unsigned LenW    = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 24;

  typedef enum logic [OpW-1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK           = 3'd0,
    ST_LEN_TIMEOUT  = 3'd1,
    ST_BAD_LENGTH   = 3'd2,
    ST_IDLE_TIMEOUT = 3'd3,
    ST_BAD_MARKERS  = 3'd4,
    ST_TRL_REJECT   = 3'd5,
    ST_TRL_ACCEPT   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEN,
    PH_PAYLOAD,
    PH_TRAILER
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_LENGTH      = 3'd0,
    REG_IDLE_TIMEOUT    = 3'd1,
    REG_TRAILER_WAIT    = 3'd2,
    REG_REQUIRE_MARKERS = 3'd3,
    REG_REQUIRE_TRAILER = 3'd4
  } reg_idx_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  // One result item as held in the output queue
  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  payload_byte;
    logic              payload_last;
    status_e           status_code;
    logic [LenW-1:0]   frame_length;
  } res_t;

  localparam logic [15:0] SoiMarker   = 16'hFFD8;
  localparam logic [15:0] EoiMarker   = 16'hFFD9;
  localparam logic [47:0] TrailerWord = 48'h444F4E450D0A;

  localparam logic [23:0] MaxLengthRst    = 24'd65536;
  localparam logic [15:0] IdleTimeoutRst  = 16'd15000;
  localparam logic [15:0] TrailerWaitRst  = 16'd2000;

endpackage

[rtl/lpir_if.sv]
// Channel interfaces: request input, result output and register write port.
interface lpir_in_if import lpir_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OpW-1:0]     operation;
  logic [ByteW-1:0]   rx_byte;

  modport source (output valid, operation, rx_byte, input ready);
  modport sink   (input valid, operation, rx_byte, output ready);
endinterface

interface lpir_out_if import lpir_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [ByteW-1:0]   payload_byte;
  logic               payload_last;
  logic [StatW-1:0]   status_code;
  logic [LenW-1:0]    frame_length;

  modport source (output valid, kind, payload_byte, payload_last, status_code, frame_length,
                  input ready);
  modport sink   (input valid, kind, payload_byte, payload_last, status_code, frame_length,
                  output ready);
endinterface

interface lpir_cfg_if import lpir_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/length_prefixed_image_receiver.sv]
// Length-prefixed image receiver: takes one request per cycle while ready (start,
// byte or millisecond tick) and updates the session state in the same cycle it is
// accepted. Results leave through a 4-entry output queue, one per cycle while the
// output is ready; a request gives at most two results (the final payload byte
// followed by a bad-marker status). The input is ready whenever the queue has two
// free slots, so with the output side taking every cycle the block sustains one
// request per clock. Register writes are always accepted and act at once.
module length_prefixed_image_receiver import lpir_pkg::*; #(
  parameter int unsigned COUNT_BITS = 24,
  parameter int unsigned TIMER_BITS = 17
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpir_in_if.sink     in_i,
  lpir_out_if.source  out_o,
  lpir_cfg_if.sink    cfg_i
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);
  localparam int unsigned CmpW   = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam logic [32:0] CountMax = (33'd1 << COUNT_BITS) - 33'd1;

  // Configuration registers
  logic [23:0] max_length_q;
  logic [15:0] idle_timeout_q;
  logic [15:0] trailer_wait_q;
  logic        require_markers_q;
  logic        require_trailer_q;

  // Session state
  phase_e                phase_q, phase_d;
  logic [LenW-1:0]       len_q, len_d;
  logic [1:0]            len_cnt_q, len_cnt_d;
  logic [COUNT_BITS-1:0] rcv_q, rcv_d;
  logic [TIMER_BITS-1:0] ms_q, ms_d;
  logic [15:0]           head_q, head_d;
  logic [15:0]           tail_q, tail_d;
  logic [47:0]           trl_q, trl_d;

  // Output queue
  res_t            queue_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  logic       in_acc, out_acc;
  logic [1:0] push_n;
  res_t       res0, res1;

  logic [TIMER_BITS-1:0] ms_inc;
  logic [LenW-1:0]       len_lim;
  logic                  markers_ok;

  assign in_i.ready  = (cnt_q <= CntW'(QDepth - 2));
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_acc     = out_o.valid && out_o.ready;
  assign cfg_i.ready = 1'b1;

  assign ms_inc  = (ms_q == '1) ? ms_q : ms_q + 1'b1;
  assign len_lim = (33'(max_length_q) < CountMax) ? LenW'(max_length_q) : LenW'(CountMax);

  always_comb begin
    phase_d    = phase_q;
    len_d      = len_q;
    len_cnt_d  = len_cnt_q;
    rcv_d      = rcv_q;
    ms_d       = ms_q;
    head_d     = head_q;
    tail_d     = tail_q;
    trl_d      = trl_q;
    push_n     = 2'd0;
    markers_ok = 1'b0;
    res0       = '{kind: KIND_STATUS, payload_byte: '0, payload_last: 1'b0,
                   status_code: ST_OK, frame_length: len_q};
    res1       = res0;

    if (in_acc) begin
      case (op_e'(in_i.operation))
        OP_START: begin
          phase_d   = PH_LEN;
          len_d     = '0;
          len_cnt_d = '0;
          rcv_d     = '0;
          ms_d      = '0;
          head_d    = '0;
          tail_d    = '0;
          trl_d     = '0;
        end
        OP_TICK: begin
          if (phase_q != PH_IDLE) begin
            ms_d = ms_inc;
            if (phase_q == PH_LEN && CmpW'(ms_inc) > CmpW'(idle_timeout_q)) begin
              push_n            = 2'd1;
              res0.status_code  = ST_LEN_TIMEOUT;
            end else if (phase_q == PH_PAYLOAD && CmpW'(ms_inc) > CmpW'(idle_timeout_q)) begin
              push_n            = 2'd1;
              res0.status_code  = ST_IDLE_TIMEOUT;
            end else if (phase_q == PH_TRAILER && CmpW'(ms_inc) >= CmpW'(trailer_wait_q)) begin
              push_n            = 2'd1;
              res0.status_code  = require_trailer_q ? ST_TRL_REJECT : ST_TRL_ACCEPT;
            end
          end
        end
        OP_BYTE: begin
          case (phase_q)
            PH_LEN: begin
              case (len_cnt_q)
                2'd0:    len_d = len_q | {24'd0, in_i.rx_byte};
                2'd1:    len_d = len_q | {16'd0, in_i.rx_byte, 8'd0};
                2'd2:    len_d = len_q | {8'd0, in_i.rx_byte, 16'd0};
                default: len_d = len_q | {in_i.rx_byte, 24'd0};
              endcase
              res0.frame_length = len_d;
              if (len_cnt_q != 2'd3) begin
                len_cnt_d = len_cnt_q + 2'd1;
              end else begin
                len_cnt_d = '0;
                if (len_d == '0 || len_d > len_lim) begin
                  push_n           = 2'd1;
                  res0.status_code = ST_BAD_LENGTH;
                end else begin
                  phase_d = PH_PAYLOAD;
                  rcv_d   = '0;
                  ms_d    = '0;
                end
              end
            end
            PH_PAYLOAD: begin
              if (rcv_q < COUNT_BITS'(2)) head_d = {head_q[7:0], in_i.rx_byte};
              tail_d = {tail_q[7:0], in_i.rx_byte};
              rcv_d  = rcv_q + 1'b1;
              ms_d   = '0;
              push_n = 2'd1;
              res0   = '{kind: KIND_PAYLOAD, payload_byte: in_i.rx_byte,
                         payload_last: (LenW'(rcv_d) == len_q),
                         status_code: ST_OK, frame_length: '0};
              markers_ok = (len_q >= LenW'(2)) && (head_d == SoiMarker) && (tail_d == EoiMarker);
              if (res0.payload_last) begin
                if (require_markers_q && !markers_ok) begin
                  push_n           = 2'd2;
                  res1.status_code = ST_BAD_MARKERS;
                end else begin
                  phase_d = PH_TRAILER;
                  trl_d   = '0;
                end
              end
            end
            PH_TRAILER: begin
              trl_d = {trl_q[39:0], in_i.rx_byte};
              if (trl_d == TrailerWord) begin
                push_n           = 2'd1;
                res0.status_code = ST_OK;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase

      // Any status closes the session
      if ((push_n == 2'd1 && res0.kind == KIND_STATUS) || push_n == 2'd2) begin
        phase_d   = PH_IDLE;
        len_cnt_d = '0;
        rcv_d     = '0;
        ms_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q      <= MaxLengthRst;
      idle_timeout_q    <= IdleTimeoutRst;
      trailer_wait_q    <= TrailerWaitRst;
      require_markers_q <= 1'b1;
      require_trailer_q <= 1'b1;
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_MAX_LENGTH:      max_length_q      <= cfg_i.data;
        REG_IDLE_TIMEOUT:    idle_timeout_q    <= cfg_i.data[15:0];
        REG_TRAILER_WAIT:    trailer_wait_q    <= cfg_i.data[15:0];
        REG_REQUIRE_MARKERS: require_markers_q <= cfg_i.data[0];
        REG_REQUIRE_TRAILER: require_trailer_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      len_q     <= '0;
      len_cnt_q <= '0;
      rcv_q     <= '0;
      ms_q      <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      trl_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      len_q     <= len_d;
      len_cnt_q <= len_cnt_d;
      rcv_q     <= rcv_d;
      ms_q      <= ms_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      trl_q     <= trl_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) queue_q[wr_ptr_q] <= res0;
    if (push_n == 2'd2) queue_q[wr_ptr_q + 1'b1] <= res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      if (out_acc) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + CntW'(push_n) - CntW'(out_acc);
    end
  end

  assign out_o.valid        = (cnt_q != '0);
  assign out_o.kind         = queue_q[rd_ptr_q].kind;
  assign out_o.payload_byte = queue_q[rd_ptr_q].payload_byte;
  assign out_o.payload_last = queue_q[rd_ptr_q].payload_last;
  assign out_o.status_code  = queue_q[rd_ptr_q].status_code;
  assign out_o.frame_length = queue_q[rd_ptr_q].frame_length;

  // A status result leaves the receiver idle
  a_status_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != 2'd0 && (res0.kind == KIND_STATUS || push_n == 2'd2)) |=> phase_q == PH_IDLE)
    else $error("session not closed after status");

  // Two results only for a final payload byte followed by a status
  a_pair_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n == 2'd2 |-> (res0.kind == KIND_PAYLOAD && res0.payload_last &&
                        res1.kind == KIND_STATUS))
    else $error("malformed result pair");

  // Queue never overflows
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QDepth))
    else $error("output queue overflow");

  // Payload phase always has a nonzero, in-range length
  a_len_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> (len_q != '0 && 33'(len_q) <= CountMax))
    else $error("payload phase with invalid length");

endmodule
